// ----- hdl/cal_pkg.sv -----
package cal_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    localparam logic [3:0] REQ_INSERT   = 4'd0;
    localparam logic [3:0] REQ_REMOVE   = 4'd1;
    localparam logic [3:0] REQ_READ_CUR = 4'd2;
    localparam logic [3:0] REQ_READ_POS = 4'd3;
    localparam logic [3:0] REQ_UPDATE   = 4'd4;
    localparam logic [3:0] REQ_START    = 4'd5;
    localparam logic [3:0] REQ_END      = 4'd6;
    localparam logic [3:0] REQ_NEXT     = 4'd7;
    localparam logic [3:0] REQ_BACK     = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EDGE  = 2'd3;

    typedef struct packed {
        logic [3:0]               req_type;
        logic [IDX_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]         list_length;
        logic [IDX_W-1:0]         cursor_index;
        logic [1:0]               status;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

// ----- hdl/cursor_array_list_top.sv -----
// channel   signals                      payload
// request   req_valid / req_ready        req  (req_type, position, value)
// response  rsp_valid / rsp_ready        rsp  (read_value, list_length, cursor_index, status)
//
// a transaction first captures the request, then executes it against the slot
// register array and loads the response register.
// a waiting response stalls execute of the next transaction until taken; the
// next request is still captured meanwhile.
// reset clears all slots, the length and the cursor at once.
module cursor_array_list_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  cal_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output cal_pkg::rsp_t rsp
);
    import cal_pkg::*;

    cmd_t cmd;

    cal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    cal_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// ----- hdl/cal_ctrl.sv -----
module cal_ctrl (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output cal_pkg::cmd_t cmd
);
    import cal_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.load       = 1'b0;
        cmd.exec       = 1'b0;
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // result register must be free before it is overwritten
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_exec_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> state_reg == S_EXEC)
        else $error("execute outside exec state");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp_ready) |-> !cmd.exec)
        else $error("pending result overwritten");

    a_exec_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> rsp_valid)
        else $error("result not presented after execute");

    a_load_then_exec_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_EXEC && !req_ready))
        else $error("transaction accepted without moving to exec");

endmodule

// ----- hdl/cal_datapath.sv -----
module cal_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  cal_pkg::cmd_t cmd,
    input  cal_pkg::req_t req,
    output cal_pkg::rsp_t rsp
);
    import cal_pkg::*;

    req_t                     req_reg;
    rsp_t                     rsp_reg, rsp_next;
    logic signed [DATA_W-1:0] slots_reg [CAPACITY];
    logic signed [DATA_W-1:0] slots_next [CAPACITY];
    logic signed [DATA_W-1:0] up_src [CAPACITY];
    logic signed [DATA_W-1:0] dn_src [CAPACITY];
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         cursor_reg, cursor_next;
    logic [IDX_W-1:0]         rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    logic [CNT_W-1:0]         cur_c;
    logic                     pos_ok;

    assign rsp     = rsp_reg;
    assign cur_c   = {1'b0, cursor_reg};
    assign pos_ok  = ({1'b0, req_reg.position} < CAP_CNT);
    assign rd_addr = (req_reg.req_type == REQ_READ_CUR) ? cursor_reg : req_reg.position;
    assign rd_data = slots_reg[rd_addr];

    // neighbor taps for the one-place shifts
    always_comb
    begin
        up_src[0] = '0;
        for (int i = 1; i < CAPACITY; i++)
        begin
            up_src[i] = slots_reg[i-1];
        end
        for (int i = 0; i < CAPACITY - 1; i++)
        begin
            dn_src[i] = slots_reg[i+1];
        end
        dn_src[CAPACITY-1] = '0;
    end

    always_comb
    begin
        logic [CNT_W-1:0] ic;
        ic                   = '0;
        slots_next           = slots_reg;
        count_next           = count_reg;
        cursor_next          = cursor_reg;
        rsp_next.read_value  = '0;
        rsp_next.status      = ST_OK;
        case (req_reg.req_type)
            REQ_INSERT:
            begin
                if (count_reg >= CAP_CNT)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        ic = CNT_W'(i);
                        if (ic == cur_c)
                        begin
                            slots_next[i] = req_reg.value;
                        end
                        else if (cur_c <= count_reg)
                        begin
                            if (ic > cur_c && ic <= count_reg)
                            begin
                                slots_next[i] = up_src[i];
                            end
                        end
                        else if (ic >= count_reg && ic < cur_c)
                        begin
                            slots_next[i] = dn_src[i];
                        end
                    end
                    count_next = count_reg + 1'b1;
                    if (cursor_reg != LAST_IDX)
                    begin
                        cursor_next = cursor_reg + 1'b1;
                    end
                end
            end
            REQ_REMOVE:
            begin
                if (count_reg == '0 || cur_c >= count_reg)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        ic = CNT_W'(i);
                        if (ic >= cur_c && (ic + 1'b1) < count_reg)
                        begin
                            slots_next[i] = dn_src[i];
                        end
                        else if (ic == count_reg - 1'b1)
                        begin
                            slots_next[i] = '0;
                        end
                    end
                    count_next = count_reg - 1'b1;
                    if (cursor_reg != '0)
                    begin
                        cursor_next = cursor_reg - 1'b1;
                    end
                end
            end
            REQ_READ_CUR:
            begin
                rsp_next.read_value = rd_data;
            end
            REQ_READ_POS:
            begin
                if (pos_ok)
                begin
                    rsp_next.read_value = rd_data;
                end
                else
                begin
                    rsp_next.status = ST_RANGE;
                end
            end
            REQ_UPDATE:
            begin
                if (pos_ok)
                begin
                    slots_next[req_reg.position] = req_reg.value;
                end
                else
                begin
                    rsp_next.status = ST_RANGE;
                end
            end
            REQ_START:
            begin
                cursor_next = '0;
            end
            REQ_END:
            begin
                cursor_next = LAST_IDX;
            end
            REQ_NEXT:
            begin
                if (cursor_reg == LAST_IDX)
                begin
                    rsp_next.status = ST_EDGE;
                end
                else
                begin
                    cursor_next = cursor_reg + 1'b1;
                end
            end
            REQ_BACK:
            begin
                if (cursor_reg == '0)
                begin
                    rsp_next.status = ST_EDGE;
                end
                else
                begin
                    cursor_next = cursor_reg - 1'b1;
                end
            end
            default:
            begin
                rsp_next.status = ST_RANGE;
            end
        endcase
        rsp_next.list_length  = count_next;
        rsp_next.cursor_index = cursor_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                slots_reg[i] <= '0;
            end
            count_reg  <= '0;
            cursor_reg <= '0;
        end
        else if (cmd.exec)
        begin
            slots_reg  <= slots_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("list length beyond capacity");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> ($stable(count_reg) && $stable(cursor_reg)))
        else $error("list state changed without execute");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && req_reg.req_type == REQ_INSERT && count_reg < CAP_CNT)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the list");

endmodule
